// File: hw/rtl/wws_pkg.sv
package wws_pkg;

  // fixed field widths
  localparam int WORD_W   = 56;
  localparam int WORD_BYTES = 7;
  localparam int IDX_W    = 12;
  localparam int CNT_W    = 7;
  localparam int WC_W     = 13;
  localparam int CFG_W    = 13;

  // defaults for the top-level parameters
  localparam int DEFAULT_DICT_DEPTH = 4096;
  localparam int DEFAULT_WORD_CHARS = 7;

  // most results reported for one query
  localparam int RESULT_CAP = 64;

  localparam logic [7:0] ANY_CHAR   = 8'h3F;
  localparam logic [7:0] QUOTE_CHAR = 8'h27;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic {
    CFG_WORD_COUNT  = 1'b0,
    CFG_MATCH_LIMIT = 1'b1
  } cfg_idx_e;

  // compare mask, expected bytes and wildcard positions of one pattern
  typedef struct packed {
    logic [WORD_W-1:0] cmpmask;
    logic [WORD_W-1:0] patreg;
    logic [WORD_W-1:0] wildpos;
  } pat_t;

endpackage

// File: hw/rtl/wws_in_if.sv
interface wws_in_if;
  import wws_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [IDX_W-1:0]  entry_index;
  logic [WORD_W-1:0] entry_word;
  logic [WORD_W-1:0] pattern;

  modport source (
    output valid, operation, entry_index, entry_word, pattern,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, entry_word, pattern,
    output ready
  );
endinterface

// File: hw/rtl/wws_out_if.sv
interface wws_out_if;
  import wws_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [WORD_W-1:0] match_word;
  logic [IDX_W-1:0]  match_index;
  logic [CNT_W-1:0]  match_count;
  logic              last;

  modport source (
    output valid, found, match_word, match_index, match_count, last,
    input  ready
  );

  modport sink (
    input  valid, found, match_word, match_index, match_count, last,
    output ready
  );
endinterface

// File: hw/rtl/wws_dict_mem.sv
module wws_dict_mem
  import wws_pkg::*;
#(
  parameter int DICT_DEPTH = DEFAULT_DICT_DEPTH,
  parameter int AW         = $clog2(DICT_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DICT_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/wws_matcher.sv
module wws_matcher
  import wws_pkg::*;
(
  input  pat_t              pat_i,
  input  logic [WORD_W-1:0] word_i,
  output logic              hit_o
);

  logic [WORD_BYTES-1:0] byte_ok;

  // per byte: no apostrophe, and a real character under every wildcard
  always_comb begin
    for (int k = 0; k < WORD_BYTES; k++) begin
      byte_ok[k] = (word_i[8*k +: 8] != QUOTE_CHAR) &&
                   !((pat_i.wildpos[8*k +: 8] != 8'h00) && (word_i[8*k +: 8] == 8'h00));
    end
  end

  assign hit_o = ((word_i & pat_i.cmpmask) == pat_i.patreg) && (&byte_ok);

endmodule

// File: hw/rtl/wildcard_word_search.sv
// load: no result; the dictionary write lands at the edge that accepts it
// query: one entry per cycle through the registered dictionary read port, except while
//   a match is held because the result sink stalls
// one query at a time; the next transaction is taken once the final result is queued
// reset clears the sequencer and the registers (word_count 0, match_limit 64);
//   dictionary contents stay undefined until loaded
module wildcard_word_search
  import wws_pkg::*;
#(
  parameter int DICT_DEPTH = DEFAULT_DICT_DEPTH,
  parameter int WORD_CHARS = DEFAULT_WORD_CHARS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  wws_in_if.sink           in_i,
  wws_out_if.source        out_o
);

  // address and counter widths
  localparam int AW  = $clog2(DICT_DEPTH);
  localparam int NW  = AW + 1;
  localparam int CW  = (NW > WC_W) ? NW : WC_W;
  localparam int CWI = (NW > IDX_W) ? NW : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  // build compare mask, expected bytes and wildcard positions of a pattern
  function automatic pat_t build_pattern(input logic [WORD_W-1:0] p);
    pat_t r;
    logic ended;
    logic [7:0] b;
    r = '0;
    ended = 1'b0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      // byte k counted from the first character (top byte)
      b = p[WORD_W-8-8*k +: 8];
      if ((k >= WORD_CHARS) || (b == 8'h00)) begin
        ended = 1'b1;
      end
      if (ended) begin
        r.cmpmask[WORD_W-8-8*k +: 8] = 8'hFF;
      end else if (b == ANY_CHAR) begin
        r.wildpos[WORD_W-8-8*k +: 8] = 8'hFF;
      end else begin
        r.cmpmask[WORD_W-8-8*k +: 8] = 8'hFF;
        r.patreg[WORD_W-8-8*k +: 8]  = b;
      end
    end
    return r;
  endfunction

  // configuration registers
  logic [WC_W-1:0]  wc_q;
  logic [CNT_W-1:0] ml_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= '0;
      ml_q <= CNT_W'(RESULT_CAP);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WORD_COUNT) begin
        wc_q <= cfg_data_i[WC_W-1:0];
      end else begin
        ml_q <= cfg_data_i[CNT_W-1:0];
      end
    end
  end

  // sequencer and scan state
  state_e           state_q, state_d;
  pat_t             pat_q, pat_d;
  logic [NW-1:0]    n_q, n_d;           // entries to scan
  logic [CNT_W-1:0] limit_q, limit_d;   // clamped match limit
  logic [CNT_W-1:0] count_q, count_d;   // matches taken so far
  logic [NW-1:0]    rd_idx_q, rd_idx_d; // next slot to read
  logic [AW-1:0]    eval_idx_q, eval_idx_d; // slot whose data sits in rdata
  logic             rvalid_q, rvalid_d;

  // pending match, held until we know whether it is the final one
  logic              pend_valid_q, pend_valid_d;
  logic [WORD_W-1:0] pend_word_q, pend_word_d;
  logic [IDX_W-1:0]  pend_index_q, pend_index_d;
  logic [CNT_W-1:0]  pend_count_q, pend_count_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic [IDX_W-1:0]  out_index_q, out_index_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              out_last_q, out_last_d;

  // dictionary ports
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              hit;

  wws_dict_mem #(
    .DICT_DEPTH (DICT_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(in_i.entry_index)),
    .wdata_i (in_i.entry_word),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared compare unit, one dictionary entry per cycle except while a match stalls
  wws_matcher u_match (
    .pat_i  (pat_q),
    .word_i (mem_rdata),
    .hit_o  (hit)
  );

  logic in_acc;
  logic push_ok;    // output register can take a result this cycle
  logic stall;      // match found but pending and output slots are full
  logic take;       // match accepted into the pending slot
  logic last_entry; // entry in rdata is the final one to scan
  logic lim_hit;    // this match reaches the limit

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign push_ok    = !out_valid_q || out_o.ready;
  assign stall      = rvalid_q && hit && pend_valid_q && !push_ok;
  assign take       = rvalid_q && hit && !stall;
  assign last_entry = rvalid_q && ({1'b0, eval_idx_q} == NW'(n_q - NW'(1)));
  assign lim_hit    = take && ((count_q + CNT_W'(1)) == limit_q);

  always_comb begin
    state_d      = state_q;
    pat_d        = pat_q;
    n_d          = n_q;
    limit_d      = limit_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    eval_idx_d   = eval_idx_q;
    rvalid_d     = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_word_d  = pend_word_q;
    pend_index_d = pend_index_q;
    pend_count_d = pend_count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_found_d  = out_found_q;
    out_word_d   = out_word_q;
    out_index_d  = out_index_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = AW'(rd_idx_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.operation == OP_LOAD) begin
            // slots beyond the depth are dropped
            mem_we = (CWI'(in_i.entry_index) < CWI'(DICT_DEPTH));
          end else begin
            pat_d = build_pattern(in_i.pattern);
            if (CW'(wc_q) > CW'(DICT_DEPTH)) begin
              n_d = NW'(DICT_DEPTH);
            end else begin
              n_d = NW'(wc_q);
            end
            if (ml_q == '0) begin
              limit_d = CNT_W'(1);
            end else if (ml_q > CNT_W'(RESULT_CAP)) begin
              limit_d = CNT_W'(RESULT_CAP);
            end else begin
              limit_d = ml_q;
            end
            count_d      = '0;
            rd_idx_d     = '0;
            pend_valid_d = 1'b0;
            // empty dictionary goes straight to the no-match result
            if (CW'(wc_q) == '0) begin
              state_d = ST_FLUSH;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (take) begin
          // earlier match is not the final one: hand it on
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_found_d = 1'b1;
            out_word_d  = pend_word_q;
            out_index_d = pend_index_q;
            out_count_d = pend_count_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_word_d  = mem_rdata;
          pend_index_d = IDX_W'(eval_idx_q);
          pend_count_d = count_q + CNT_W'(1);
          count_d      = count_q + CNT_W'(1);
        end

        if (stall) begin
          // re-read the same entry and try again next cycle
          mem_re     = 1'b1;
          mem_raddr  = eval_idx_q;
          eval_idx_d = eval_idx_q;
          rd_idx_d   = {1'b0, eval_idx_q} + NW'(1);
          rvalid_d   = 1'b1;
        end else if (last_entry || lim_hit) begin
          state_d = ST_FLUSH;
        end else if (rd_idx_q < n_q) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(rd_idx_q);
          eval_idx_d = AW'(rd_idx_q);
          rd_idx_d   = rd_idx_q + NW'(1);
          rvalid_d   = 1'b1;
        end
      end

      ST_FLUSH: begin
        // final result: the pending match, or the no-match marker
        if (push_ok) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_found_d  = pend_valid_q;
          out_word_d   = pend_valid_q ? pend_word_q : '0;
          out_index_d  = pend_valid_q ? pend_index_q : '0;
          out_count_d  = pend_valid_q ? pend_count_q : '0;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      n_q          <= '0;
      limit_q      <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      eval_idx_q   <= '0;
      rvalid_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      limit_q      <= limit_d;
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      eval_idx_q   <= eval_idx_d;
      rvalid_q     <= rvalid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    pat_q        <= pat_d;
    pend_word_q  <= pend_word_d;
    pend_index_q <= pend_index_d;
    pend_count_q <= pend_count_d;
    out_found_q  <= out_found_d;
    out_word_q   <= out_word_d;
    out_index_q  <= out_index_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.match_word  = out_word_q;
  assign out_o.match_index = out_index_q;
  assign out_o.match_count = out_count_q;
  assign out_o.last        = out_last_q;

  // pending match always carries the running count
  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_count_q == count_q) && (count_q != '0))
    else $error("pending match count out of step");

  // data in the read register always belongs to a slot inside the scan range
  a_eval_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == ST_SCAN) && ({1'b0, eval_idx_q} < n_q))
    else $error("evaluated slot outside scan range");

  // a no-match result is always the final one and carries no count
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_last_q && (out_count_q == '0)))
    else $error("malformed no-match result");

  // scanning never runs past the match limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q < limit_q))
    else $error("scan past match limit");

endmodule
